// ----- rtl/gbts_pkg.sv -----
// Shared constants and payload types of the gap buffer text store.
package gbts_pkg;

   localparam int CAPACITY_DEF = 1024;

   localparam int POS_W    = 11;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic              func;
      logic [POS_W-1:0]  position;
      logic [BYTE_W-1:0] insert_byte;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   read_byte;
      logic [POS_W-1:0]    text_length;
   } rsp_type;

endpackage

// ----- rtl/gap_buffer_text_store_unit.sv -----
// Gap buffer text store: one byte memory, a gap mover and a result register.
//
//   channel   ports                         direction   payload
//   request   req_valid req_ready req_data  in          gbts_pkg::req_type
//   response  rsp_valid rsp_ready rsp_data  out         gbts_pkg::rsp_type
//
// A read passes the evaluate, memory-wait and response states; a rejected
// read or insert goes from evaluate straight to response. An accepted insert
// first moves the gap to the insert position; the mover copies one byte a
// cycle over the single read and single write port of the text memory.
// Reset empties the text at once (gap at 0, gap as large as the store).
// A request is taken only between items; a waiting response does not block
// the next request, but the following result waits until the register frees.
module gap_buffer_text_store_unit #(
   parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gbts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gbts_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int LW     = (CNT_W > gbts_pkg::POS_W) ? CNT_W : gbts_pkg::POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_MOVE   = 3'd2;
   localparam logic [2:0] S_RDWAIT = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [gbts_pkg::BYTE_W-1:0] text_store_ff [CAPACITY];
   logic [gbts_pkg::BYTE_W-1:0] rdata_ff;

   logic [2:0]        state_ff, state_in;
   gbts_pkg::req_type req_ff, req_in;
   logic [CNT_W-1:0]  gb_ff, gb_in;
   logic [CNT_W-1:0]  gs_ff, gs_in;
   logic [CNT_W-1:0]  src_ff, src_in;
   logic [CNT_W-1:0]  dst_ff, dst_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic              pend_ff, pend_in;
   logic              back_ff, back_in;
   gbts_pkg::rsp_type res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   gbts_pkg::rsp_type rsp_ff, rsp_in;

   logic                        mem_we;
   logic [ADDR_W-1:0]           mem_waddr;
   logic [gbts_pkg::BYTE_W-1:0] mem_wdata;
   logic                        mem_re;
   logic [ADDR_W-1:0]           mem_raddr;

   logic [LW-1:0]    pos_ext;
   logic [LW-1:0]    len_ext;
   logic [LW-1:0]    gb_ext;
   logic [LW-1:0]    phys_ext;
   logic [CNT_W-1:0] gs_dec;
   logic [LW-1:0]    len_after_ext;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pos_ext       = LW'(req_ff.position);
   assign len_ext       = LW'(CAP_CNT - gs_ff);
   assign gb_ext        = LW'(gb_ff);
   assign phys_ext      = (pos_ext < gb_ext) ? pos_ext : pos_ext + LW'(gs_ff);
   assign gs_dec        = gs_ff - CNT_W'(1);
   assign len_after_ext = LW'(CAP_CNT - gs_dec);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      gb_in        = gb_ff;
      gs_in        = gs_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      back_in      = back_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = dst_ff[ADDR_W-1:0];
      mem_wdata    = rdata_ff;
      mem_re       = 1'b0;
      mem_raddr    = src_ff[ADDR_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            res_in.status      = gbts_pkg::ST_OK;
            res_in.read_byte   = '0;
            res_in.text_length = len_ext[gbts_pkg::POS_W-1:0];
            state_in           = S_RESP;
            if (req_ff.func == gbts_pkg::FUNC_INSERT) begin
               if (gs_ff == '0) begin
                  res_in.status = gbts_pkg::ST_FULL;
               end else if (pos_ext > len_ext) begin
                  res_in.status = gbts_pkg::ST_RANGE;
               end else begin
                  pend_in  = 1'b0;
                  state_in = S_MOVE;
                  if (pos_ext < gb_ext) begin
                     // copy the bytes below the gap up to its far end, top first
                     back_in = 1'b1;
                     src_in  = gb_ff - CNT_W'(1);
                     rem_in  = gb_ff - pos_ext[CNT_W-1:0];
                  end else begin
                     back_in = 1'b0;
                     src_in  = gb_ff + gs_ff;
                     rem_in  = pos_ext[CNT_W-1:0] - gb_ff;
                  end
               end
            end else begin
               if (pos_ext >= len_ext) begin
                  res_in.status = gbts_pkg::ST_RANGE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = phys_ext[ADDR_W-1:0];
                  state_in  = S_RDWAIT;
               end
            end
         end
         S_MOVE: begin
            // write back the byte read last cycle while the next one is fetched
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (rem_ff != '0) begin
               mem_re  = 1'b1;
               pend_in = 1'b1;
               dst_in  = back_ff ? src_ff + gs_ff : src_ff - gs_ff;
               src_in  = back_ff ? src_ff - CNT_W'(1) : src_ff + CNT_W'(1);
               rem_in  = rem_ff - CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (rem_ff == '0 && !pend_ff) begin
               mem_we             = 1'b1;
               mem_waddr          = pos_ext[ADDR_W-1:0];
               mem_wdata          = req_ff.insert_byte;
               gb_in              = pos_ext[CNT_W-1:0] + CNT_W'(1);
               gs_in              = gs_dec;
               res_in.text_length = len_after_ext[gbts_pkg::POS_W-1:0];
               state_in           = S_RESP;
            end
         end
         S_RDWAIT: begin
            res_in.read_byte = rdata_ff;
            state_in         = S_RESP;
         end
         S_RESP: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         text_store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= text_store_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gb_ff        <= '0;
         gs_ff        <= CAP_CNT;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gb_ff        <= gb_in;
         gs_ff        <= gs_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      rem_ff  <= rem_in;
      back_ff <= back_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   a_gap_in_store: assert property (@(posedge clock) disable iff (reset)
      (LW + 1)'(gb_ff) + (LW + 1)'(gs_ff) <= (LW + 1)'(CAP_CNT))
      else $error("gap extends past the end of the store");

   a_no_port_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("gap move writes the entry it reads in the same cycle");

   a_gap_shrinks_by_one: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && gs_ff != $past(gs_ff)) |-> (gs_ff == $past(gs_ff) - CNT_W'(1)))
      else $error("gap size changed by other than one insert");

   a_move_ends_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE && state_in == S_RESP) |-> (!pend_ff && rem_ff == '0))
      else $error("insert finished with copies outstanding");

endmodule
